@@ hdl/efws_pkg.sv @@
// Package for the earliest-free worker scheduler.
// Holds field widths, the reset worker count, the controller state type and the cell control struct.
// Depends on nothing.
package efws_pkg;

  localparam int unsigned CFG_W      = 5;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned ID_OUT_W   = 4;
  localparam int unsigned START_W    = 48;
  localparam int unsigned RST_COUNT  = 16;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_INSERT
  } efws_state_e;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic init;    // reload time zero and the cell's own position as id
    logic update;  // perform one replace-head-and-insert step
  } efws_ctrl_t;

endpackage

@@ hdl/efws_cell.sv @@
// One cell of the sorted scheduler chain: holds one (free time, worker id) pair.
// Depends on efws_pkg for the control struct.
module efws_cell import efws_pkg::*; #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned ID_BITS   = 4,
  parameter int unsigned POS       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  efws_ctrl_t           ctrl_i,
  input  logic [TIME_BITS-1:0] new_time_i,
  input  logic [ID_BITS-1:0]   new_id_i,
  input  logic                 right_valid_i,
  input  logic [TIME_BITS-1:0] right_time_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  input  logic                 left_take_i,
  output logic                 take_o,
  output logic [TIME_BITS-1:0] time_o,
  output logic [ID_BITS-1:0]   id_o
);

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic                 right_first;

  // The right neighbor orders ahead of the new entry, so it moves down here.
  assign right_first = right_valid_i &&
                       ((right_time_i < new_time_i) ||
                        ((right_time_i == new_time_i) && (right_id_i < new_id_i)));
  assign take_o = right_first;

  always_comb begin
    time_d = time_q;
    id_d   = id_q;
    if (ctrl_i.init) begin
      time_d = '0;
      id_d   = ID_BITS'(POS);
    end else if (ctrl_i.update) begin
      if (right_first) begin
        time_d = right_time_i;
        id_d   = right_id_i;
      end else if (left_take_i) begin
        time_d = new_time_i;
        id_d   = new_id_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      id_q   <= ID_BITS'(POS);
    end else begin
      time_q <= time_d;
      id_q   <= id_d;
    end
  end

  assign time_o = time_q;
  assign id_o   = id_q;

endmodule

@@ hdl/earliest_free_worker_scheduler_unit.sv @@
// Top level of the earliest-free worker scheduler.
// Depends on efws_pkg and instantiates one efws_cell per worker slot.
//
// Each job beat is assigned to the worker that becomes free earliest, with
// ties going to the lowest worker number. The workers' (free time, id) pairs
// live in a chain of MAX_WORKERS cells kept in ascending order, so the head
// cell always holds the next worker to use; this yields the same assignment
// sequence as a binary min-heap ordered by time, then id. When a job beat is
// taken, the head's id and free time are registered as the result beat, and
// the head's time plus the duration (saturating at the largest TIME_BITS
// value) is registered. In the following cycle every cell compares
// its right neighbor with that new entry in parallel and either takes the
// neighbor's pair, takes the new entry, or holds, which removes the old head
// and inserts the updated one in a single shift. No new job is taken during
// that step; a job with a zero duration skips it, since the order is
// left unchanged. A result beat waits in its output register while the next
// job is accepted, provided that register is free or drains in that cycle.
// Writing worker_count (clamped to 1..MAX_WORKERS) restores all times to zero
// and ids to their positions; no clearing pass is needed.
module earliest_free_worker_scheduler_unit import efws_pkg::*; #(
  parameter int unsigned MAX_WORKERS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: worker_count.
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  // Job channel.
  input  logic                job_valid_i,
  output logic                job_stall_o,
  input  logic [DUR_W-1:0]    job_duration_i,
  // Result channel.
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output logic [ID_OUT_W-1:0] worker_id_o,
  output logic [START_W-1:0]  launch_time_o
);

  localparam int unsigned ID_BITS = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_WORKERS + 1);
  localparam int unsigned CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned RST_CNT = (RST_COUNT < MAX_WORKERS) ? RST_COUNT : MAX_WORKERS;

  efws_state_e state_q, state_d;
  efws_ctrl_t  ctrl;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CMP_W-1:0]     wdata_ext;

  logic [TIME_BITS-1:0] new_time_q, new_time_d;
  logic [ID_BITS-1:0]   new_id_q;
  logic                 res_valid_q, res_valid_d;
  logic [ID_OUT_W-1:0]  worker_id_q;
  logic [START_W-1:0]   launch_time_q;

  logic                 job_accept;
  logic [TIME_BITS:0]   sum;
  logic [ID_BITS+ID_OUT_W-1:0]  id_ext;
  logic [TIME_BITS+START_W-1:0] time_ext;

  // Chain wiring; index MAX_WORKERS is the empty slot past the last cell.
  logic [TIME_BITS-1:0] cell_time [MAX_WORKERS+1];
  logic [ID_BITS-1:0]   cell_id   [MAX_WORKERS+1];
  logic                 cell_take [MAX_WORKERS];

  assign cell_time[MAX_WORKERS] = '0;
  assign cell_id[MAX_WORKERS]   = '0;

  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    logic right_valid;
    logic left_take;

    // Cells at or past the worker count never move.
    assign right_valid = (CNT_W'(i + 1) < count_q);
    if (i == 0) begin : g_head
      assign left_take = 1'b1;
    end else begin : g_body
      assign left_take = cell_take[i-1];
    end

    efws_cell #(
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS),
      .POS       (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_time_i    (new_time_q),
      .new_id_i      (new_id_q),
      .right_valid_i (right_valid),
      .right_time_i  (cell_time[i+1]),
      .right_id_i    (cell_id[i+1]),
      .left_take_i   (left_take),
      .take_o        (cell_take[i]),
      .time_o        (cell_time[i]),
      .id_o          (cell_id[i])
    );
  end

  // A new job may enter while idle, when the result register is free or
  // hands its beat on in this same cycle.
  assign job_stall_o = (state_q != ST_IDLE) || (res_valid_q && res_stall_i);
  assign job_accept  = job_valid_i && !job_stall_o;

  // Saturating add of the duration to the head's free time.
  assign sum = {1'b0, cell_time[0]} +
               {{(TIME_BITS + 1 - DUR_W){1'b0}}, job_duration_i};
  assign new_time_d = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  // Fit the internal id and time onto the fixed result field widths.
  assign id_ext   = {{ID_OUT_W{1'b0}}, cell_id[0]};
  assign time_ext = {{START_W{1'b0}}, cell_time[0]};

  // Worker count clamp: zero means one worker, large values saturate.
  assign wdata_ext = CMP_W'(cfg_wdata_i);
  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      if (wdata_ext == '0) begin
        count_d = CNT_W'(1);
      end else if (wdata_ext > CMP_W'(MAX_WORKERS)) begin
        count_d = CNT_W'(MAX_WORKERS);
      end else begin
        count_d = wdata_ext[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl.init   = cfg_we_i;
    ctrl.update = 1'b0;
    res_valid_d = res_valid_q;
    if (res_valid_q && !res_stall_i) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (job_accept) begin
          res_valid_d = 1'b1;
          if (job_duration_i != '0) begin
            state_d = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        ctrl.update = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CNT_W'(RST_CNT);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_accept) begin
      new_time_q    <= new_time_d;
      new_id_q      <= cell_id[0];
      worker_id_q   <= id_ext[ID_OUT_W-1:0];
      launch_time_q <= time_ext[START_W-1:0];
    end
  end

  assign res_valid_o   = res_valid_q;
  assign worker_id_o   = worker_id_q;
  assign launch_time_o = launch_time_q;

  // A job with a nonzero duration always triggers the insert step next.
  a_insert_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_accept && (job_duration_i != '0) |=> state_q == ST_INSERT)
    else $error("insert step did not follow a nonzero job");

  // Between jobs the head must order no later than its neighbor.
  a_head_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && (count_q > CNT_W'(1)) |->
      (cell_time[0] < cell_time[1]) ||
      ((cell_time[0] == cell_time[1]) && (cell_id[0] < cell_id[1])))
    else $error("head cell is not the earliest free worker");

  // Every accepted job produces a result beat in the next cycle.
  a_result_after_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_accept |=> res_valid_o)
    else $error("accepted job produced no result beat");

endmodule
